// File: hdl/bcd_clock_date_set_editor_top_defines.svh
// Assertion helpers used by the checker file.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef BCD_CLOCK_DATE_SET_EDITOR_TOP_DEFINES_SVH
`define BCD_CLOCK_DATE_SET_EDITOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define BCDCE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCDCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bcdce_pkg.sv
package bcdce_pkg;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_YEAR    = 7'b0000010,
    PH_MONTH   = 7'b0000100,
    PH_DAY     = 7'b0001000,
    PH_WEEKDAY = 7'b0010000,
    PH_HOUR    = 7'b0100000,
    PH_MINUTE  = 7'b1000000
  } phase_t;

  typedef enum logic [2:0] {
    SEL_IDLE    = 3'd0,
    SEL_YEAR    = 3'd1,
    SEL_MONTH   = 3'd2,
    SEL_DAY     = 3'd3,
    SEL_WEEKDAY = 3'd4,
    SEL_HOUR    = 3'd5,
    SEL_MINUTE  = 3'd6
  } field_sel_t;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_INCR    = 1'b1;

  localparam logic [7:0] YEAR_TOP    = 8'd99;
  localparam logic [7:0] MONTH_TOP   = 8'd12;
  localparam logic [7:0] HOUR_TOP    = 8'd23;
  localparam logic [7:0] MINUTE_TOP  = 8'd59;
  localparam logic [2:0] WEEKDAY_TOP = 3'd6;
  localparam logic [7:0] LEN_LONG    = 8'd31;
  localparam logic [7:0] LEN_SHORT   = 8'd30;
  localparam logic [7:0] LEN_FEB     = 8'd28;
  localparam logic [7:0] LEN_FEB_LP  = 8'd29;

  typedef struct packed {
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [2:0] weekday;
    logic [5:0] hour;
    logic [6:0] minute;
  } fields_t;

  typedef struct packed {
    phase_t  phase;
    fields_t f;
    logic    commit;
  } step_t;

  // Packed BCD to binary, digits above 9 taken at face value.
  function automatic logic [7:0] bcd_val(logic [7:0] x);
    return {1'b0, x[7:4], 3'b000} + {3'b000, x[7:4], 1'b0} + {4'b0000, x[3:0]};
  endfunction

  // Binary 0..99 to packed BCD; tens by reciprocal multiply.
  function automatic logic [7:0] bcd_of(logic [7:0] v);
    logic [15:0] p;
    logic [3:0]  tens;
    logic [7:0]  ones;
    p    = {8'd0, v} * 16'd205;
    tens = p[14:11];
    ones = v - ({1'b0, tens, 3'b000} + {3'b000, tens, 1'b0});
    return {tens, ones[3:0]};
  endfunction

  function automatic logic [7:0] bcd_step(logic [7:0] x, logic [7:0] bottom,
                                          logic [7:0] top);
    logic [7:0] v;
    v = bcd_val(x);
    if (v >= top) begin
      return bcd_of(bottom);
    end
    return bcd_of(v + 8'd1);
  endfunction

  function automatic logic [7:0] month_len(logic [4:0] month, logic [7:0] year);
    logic [7:0] m;
    logic [7:0] y;
    logic [7:0] len;
    m = bcd_val({3'b000, month});
    y = bcd_val(year);
    case (m) inside
      8'd4, 8'd6, 8'd9, 8'd11: len = LEN_SHORT;
      8'd2:                    len = (y[1:0] == 2'b00) ? LEN_FEB_LP : LEN_FEB;
      default:                 len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

// File: hdl/bcdce_in_if.sv
interface bcdce_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] now_year;
  logic [4:0] now_month;
  logic [5:0] now_day;
  logic [2:0] now_weekday;
  logic [5:0] now_hour;
  logic [6:0] now_minute;

  modport source (
    output valid, op, now_year, now_month, now_day, now_weekday, now_hour, now_minute,
    input  ready
  );
  modport sink (
    input  valid, op, now_year, now_month, now_day, now_weekday, now_hour, now_minute,
    output ready
  );
endinterface

// File: hdl/bcdce_out_if.sv
interface bcdce_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] field_sel;
  logic [7:0] edit_year;
  logic [4:0] edit_month;
  logic [5:0] edit_day;
  logic [2:0] edit_weekday;
  logic [5:0] edit_hour;
  logic [6:0] edit_minute;
  logic       commit;

  modport source (
    output valid, field_sel, edit_year, edit_month, edit_day, edit_weekday,
           edit_hour, edit_minute, commit,
    input  ready
  );
  modport sink (
    input  valid, field_sel, edit_year, edit_month, edit_day, edit_weekday,
           edit_hour, edit_minute, commit,
    output ready
  );
endinterface

// File: hdl/bcd_clock_date_set_editor_top.sv
// Set-mode editor for a BCD clock and calendar. Each input transaction is one
// button event (advance or increment) together with the current time and date;
// each produces exactly one output transaction carrying the selected field, the
// six edit values and a commit flag that is high on the event that leaves the
// minute field. The editor state and the result register update at the same
// clock edge, so a result is offered in the cycle after its event is taken. The
// result register is refilled at the edge where its content is taken: with
// out_ready held high one event is taken every cycle, and while a result waits
// the input is held off. A cfg_we write sets the date enable (reset 1), which
// takes effect at the next entry from idle.
module bcd_clock_date_set_editor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  bcdce_in_if.sink    in_ch,
  bcdce_out_if.source out_ch
);

  logic               date_en_r;
  bcdce_pkg::phase_t  phase_r;
  bcdce_pkg::fields_t cur_r;
  bcdce_pkg::fields_t now;
  bcdce_pkg::step_t   nxt;
  logic               accept;

  logic               out_valid_r;
  logic [2:0]         sel_r;
  bcdce_pkg::fields_t out_f_r;
  logic               commit_r;
  logic [2:0]         sel_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign now.year    = in_ch.now_year;
  assign now.month   = in_ch.now_month;
  assign now.day     = in_ch.now_day;
  assign now.weekday = in_ch.now_weekday;
  assign now.hour    = in_ch.now_hour;
  assign now.minute  = in_ch.now_minute;

  bcdce_next u_next (
    .phase   (phase_r),
    .cur     (cur_r),
    .now     (now),
    .op      (in_ch.op),
    .date_en (date_en_r),
    .nxt     (nxt)
  );

  always_comb begin
    unique case (nxt.phase)
      bcdce_pkg::PH_IDLE:    sel_nxt = bcdce_pkg::SEL_IDLE;
      bcdce_pkg::PH_YEAR:    sel_nxt = bcdce_pkg::SEL_YEAR;
      bcdce_pkg::PH_MONTH:   sel_nxt = bcdce_pkg::SEL_MONTH;
      bcdce_pkg::PH_DAY:     sel_nxt = bcdce_pkg::SEL_DAY;
      bcdce_pkg::PH_WEEKDAY: sel_nxt = bcdce_pkg::SEL_WEEKDAY;
      bcdce_pkg::PH_HOUR:    sel_nxt = bcdce_pkg::SEL_HOUR;
      bcdce_pkg::PH_MINUTE:  sel_nxt = bcdce_pkg::SEL_MINUTE;
      default:               sel_nxt = bcdce_pkg::SEL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_en_r <= 1'b1;
    end else if (cfg_we) begin
      date_en_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bcdce_pkg::PH_IDLE;
      cur_r   <= '0;
    end else if (accept) begin
      phase_r <= nxt.phase;
      cur_r   <= nxt.f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      sel_r    <= sel_nxt;
      out_f_r  <= nxt.f;
      commit_r <= nxt.commit;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.field_sel    = sel_r;
  assign out_ch.edit_year    = out_f_r.year;
  assign out_ch.edit_month   = out_f_r.month;
  assign out_ch.edit_day     = out_f_r.day;
  assign out_ch.edit_weekday = out_f_r.weekday;
  assign out_ch.edit_hour    = out_f_r.hour;
  assign out_ch.edit_minute  = out_f_r.minute;
  assign out_ch.commit       = commit_r;

endmodule

// File: hdl/bcdce_next.sv
module bcdce_next (
  input  bcdce_pkg::phase_t  phase,
  input  bcdce_pkg::fields_t cur,
  input  bcdce_pkg::fields_t now,
  input  logic               op,
  input  logic               date_en,
  output bcdce_pkg::step_t   nxt
);

  logic [7:0] mlen;
  logic [7:0] day_val;

  assign mlen    = bcdce_pkg::month_len(cur.month, cur.year);
  assign day_val = bcdce_pkg::bcd_val({2'b00, cur.day});

  always_comb begin
    nxt.phase  = phase;
    nxt.f      = cur;
    nxt.commit = 1'b0;
    if (op == bcdce_pkg::OP_ADVANCE) begin
      unique case (phase)
        bcdce_pkg::PH_IDLE: begin
          nxt.f     = now;
          nxt.phase = date_en ? bcdce_pkg::PH_YEAR : bcdce_pkg::PH_HOUR;
        end
        bcdce_pkg::PH_YEAR:    nxt.phase = bcdce_pkg::PH_MONTH;
        bcdce_pkg::PH_MONTH: begin
          nxt.phase = bcdce_pkg::PH_DAY;
          // clamp an out-of-range day to the first
          if (day_val > mlen) begin
            nxt.f.day = 6'h01;
          end
        end
        bcdce_pkg::PH_DAY:     nxt.phase = bcdce_pkg::PH_WEEKDAY;
        bcdce_pkg::PH_WEEKDAY: nxt.phase = bcdce_pkg::PH_HOUR;
        bcdce_pkg::PH_HOUR:    nxt.phase = bcdce_pkg::PH_MINUTE;
        bcdce_pkg::PH_MINUTE: begin
          nxt.phase  = bcdce_pkg::PH_IDLE;
          nxt.commit = 1'b1;
        end
        default:               nxt.phase = bcdce_pkg::PH_IDLE;
      endcase
    end else begin
      unique case (phase)
        bcdce_pkg::PH_IDLE: ;
        bcdce_pkg::PH_YEAR:
          nxt.f.year = bcdce_pkg::bcd_step(cur.year, 8'd0, bcdce_pkg::YEAR_TOP);
        bcdce_pkg::PH_MONTH:
          nxt.f.month = 5'(bcdce_pkg::bcd_step({3'b000, cur.month}, 8'd1,
                                               bcdce_pkg::MONTH_TOP));
        bcdce_pkg::PH_DAY:
          nxt.f.day = 6'(bcdce_pkg::bcd_step({2'b00, cur.day}, 8'd1, mlen));
        bcdce_pkg::PH_WEEKDAY:
          nxt.f.weekday = (cur.weekday >= bcdce_pkg::WEEKDAY_TOP) ? 3'd0
                                                                  : cur.weekday + 3'd1;
        bcdce_pkg::PH_HOUR:
          nxt.f.hour = 6'(bcdce_pkg::bcd_step({2'b00, cur.hour}, 8'd0,
                                              bcdce_pkg::HOUR_TOP));
        bcdce_pkg::PH_MINUTE:
          nxt.f.minute = 7'(bcdce_pkg::bcd_step({1'b0, cur.minute}, 8'd0,
                                                bcdce_pkg::MINUTE_TOP));
        default:               nxt.phase = bcdce_pkg::PH_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/bcdce_checker.sv
`include "bcd_clock_date_set_editor_top_defines.svh"

module bcdce_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_field_sel,
  input logic [7:0] out_edit_year,
  input logic       out_commit
);

  // commit always lands back in idle
  `BCDCE_ASSERT_NOW(a_commit_idle, out_valid && out_commit, out_field_sel == bcdce_pkg::SEL_IDLE, "commit outside idle")

  `BCDCE_ASSERT_NOW(a_sel_range, out_valid, out_field_sel <= bcdce_pkg::SEL_MINUTE, "field select out of range")

  // an empty result register never blocks the input
  `BCDCE_ASSERT_NOW(a_ready_empty, !out_valid, in_ready, "input stalled with no pending result")

  `BCDCE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_field_sel) && $stable(out_edit_year) && $stable(out_commit), "stalled result changed")

endmodule

bind bcd_clock_date_set_editor_top bcdce_checker u_bcdce_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_field_sel (out_ch.field_sel),
  .out_edit_year (out_ch.edit_year),
  .out_commit    (out_ch.commit)
);

// File: tb/sv/tb_top.sv
module tb_top;

  localparam int CLK_HALF      = 6;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RX_HOLD_AFTER = 300;
  localparam int RX_LONG_HOLD  = 60;
  localparam int NUM_PHASES    = 6;

  typedef struct packed {
    bcdce_pkg::field_sel_t sel;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [2:0] wday;
    logic [5:0] hour;
    logic [6:0] minute;
    logic       commit;
  } edit_rec_t;

  typedef struct packed {
    logic       op;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [2:0] wday;
    logic [5:0] hour;
    logic [6:0] minute;
    logic       typed;
    edit_rec_t  want;
  } button_row_t;

  localparam edit_rec_t NO_CHECK = '{bcdce_pkg::SEL_IDLE, 8'h00, 5'h00, 6'h00, 3'd0,
                                     6'h00, 7'h00, 1'b0};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  bcdce_in_if  in_ch ();
  bcdce_out_if out_ch ();

  bcd_clock_date_set_editor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Editor state as the block should hold it, reset values included.
  logic                  date_en   = 1'b1;
  bcdce_pkg::field_sel_t ed_sel    = bcdce_pkg::SEL_IDLE;
  logic [7:0]            ed_year   = '0;
  logic [4:0]            ed_month  = '0;
  logic [5:0]            ed_day    = '0;
  logic [2:0]            ed_wday   = '0;
  logic [5:0]            ed_hour   = '0;
  logic [6:0]            ed_minute = '0;

  edit_rec_t             pending_edits [$];
  button_row_t           offered_rows [$];
  bcdce_pkg::field_sel_t ui_sel = bcdce_pkg::SEL_IDLE;
  int          err_count    = 0;
  int          rx_count     = 0;
  int          quiet_cycles = 0;
  int          tx_gap_pct   = 0;
  int          rx_gap_pct   = 0;
  bit          rx_held      = 1'b0;

  int   phase_tx    [NUM_PHASES] = '{15, 15, 77, 77, 0, 0};
  int   phase_rx    [NUM_PHASES] = '{77, 77, 15, 15, 0, 0};
  int   phase_items [NUM_PHASES] = '{350, 350, 350, 350, 250, 250};
  logic phase_date  [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  button_row_t dir_rows [26] = '{
    // increment while idle leaves everything as reset
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b1,
      '{bcdce_pkg::SEL_IDLE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0}},
    '{bcdce_pkg::OP_ADVANCE, 8'h99, 5'h12, 6'h31, 3'd6, 6'h23, 7'h59, 1'b1,
      '{bcdce_pkg::SEL_YEAR, 8'h99, 5'h12, 6'h31, 3'd6, 6'h23, 7'h59, 1'b0}},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b1,
      '{bcdce_pkg::SEL_YEAR, 8'h00, 5'h12, 6'h31, 3'd6, 6'h23, 7'h59, 1'b0}},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b1,
      '{bcdce_pkg::SEL_MONTH, 8'h00, 5'h01, 6'h31, 3'd6, 6'h23, 7'h59, 1'b0}},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b1,
      '{bcdce_pkg::SEL_DAY, 8'h00, 5'h01, 6'h01, 3'd6, 6'h23, 7'h59, 1'b0}},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b1,
      '{bcdce_pkg::SEL_WEEKDAY, 8'h00, 5'h01, 6'h01, 3'd0, 6'h23, 7'h59, 1'b0}},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b1,
      '{bcdce_pkg::SEL_HOUR, 8'h00, 5'h01, 6'h01, 3'd0, 6'h00, 7'h59, 1'b0}},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b1,
      '{bcdce_pkg::SEL_MINUTE, 8'h00, 5'h01, 6'h01, 3'd0, 6'h00, 7'h00, 1'b0}},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b1,
      '{bcdce_pkg::SEL_IDLE, 8'h00, 5'h01, 6'h01, 3'd0, 6'h00, 7'h00, 1'b1}},
    // non-BCD digits in year, hour and minute, weekday 7, February with a day past its end
    '{bcdce_pkg::OP_ADVANCE, 8'h9A, 5'h02, 6'h31, 3'd7, 6'h3F, 7'h7F, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_INCR, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK},
    '{bcdce_pkg::OP_ADVANCE, 8'h00, 5'h00, 6'h00, 3'd0, 6'h00, 7'h00, 1'b0, NO_CHECK}
  };

  function automatic int unsigned decimal_of(logic [7:0] x);
    return int'(x[7:4]) * 10 + int'(x[3:0]);
  endfunction

  function automatic logic [7:0] packed_bcd(int unsigned v);
    logic [7:0] r;
    r[7:4] = 4'(v / 10);
    r[3:0] = 4'(v % 10);
    return r;
  endfunction

  function automatic logic [7:0] bump_bcd(logic [7:0] x, int unsigned lo, int unsigned hi);
    return (decimal_of(x) >= hi) ? packed_bcd(lo) : packed_bcd(decimal_of(x) + 1);
  endfunction

  function automatic int unsigned days_in_edit_month();
    int unsigned m;
    m = decimal_of({3'b000, ed_month});
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    if (m == 2) begin
      return (decimal_of(ed_year) % 4 == 0) ? 29 : 28;
    end
    return 31;
  endfunction

  function automatic edit_rec_t apply_button(logic op, logic [7:0] y, logic [4:0] mo,
                                             logic [5:0] d, logic [2:0] w, logic [5:0] h,
                                             logic [6:0] mi);
    logic commit_now;
    commit_now = 1'b0;
    if (op == bcdce_pkg::OP_ADVANCE) begin
      if (ed_sel == bcdce_pkg::SEL_IDLE) begin
        ed_year   = y;
        ed_month  = mo;
        ed_day    = d;
        ed_wday   = w;
        ed_hour   = h;
        ed_minute = mi;
        ed_sel    = date_en ? bcdce_pkg::SEL_YEAR : bcdce_pkg::SEL_HOUR;
      end else if (ed_sel == bcdce_pkg::SEL_MINUTE) begin
        ed_sel     = bcdce_pkg::SEL_IDLE;
        commit_now = 1'b1;
      end else begin
        ed_sel = bcdce_pkg::field_sel_t'(ed_sel + 3'd1);
        // clamp a day that does not fit the edited month; zero stays
        if (ed_sel == bcdce_pkg::SEL_DAY &&
            decimal_of({2'b00, ed_day}) > days_in_edit_month()) begin
          ed_day = 6'h01;
        end
      end
    end else begin
      case (ed_sel)
        bcdce_pkg::SEL_YEAR:    ed_year   = bump_bcd(ed_year, 0, 99);
        bcdce_pkg::SEL_MONTH:   ed_month  = 5'(bump_bcd({3'b000, ed_month}, 1, 12));
        bcdce_pkg::SEL_DAY:
          ed_day = 6'(bump_bcd({2'b00, ed_day}, 1, days_in_edit_month()));
        bcdce_pkg::SEL_WEEKDAY: ed_wday   = (ed_wday >= 3'd6) ? 3'd0 : ed_wday + 3'd1;
        bcdce_pkg::SEL_HOUR:    ed_hour   = 6'(bump_bcd({2'b00, ed_hour}, 0, 23));
        bcdce_pkg::SEL_MINUTE:  ed_minute = 7'(bump_bcd({1'b0, ed_minute}, 0, 59));
        default: ;
      endcase
    end
    return '{ed_sel, ed_year, ed_month, ed_day, ed_wday, ed_hour, ed_minute, commit_now};
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_v);
    if (got !== exp_v) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_v));
    end
  endtask

  task automatic offer(button_row_t row);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= row.op;
    in_ch.now_year    <= row.year;
    in_ch.now_month   <= row.month;
    in_ch.now_day     <= row.day;
    in_ch.now_weekday <= row.wday;
    in_ch.now_hour    <= row.hour;
    in_ch.now_minute  <= row.minute;
    offered_rows.push_back(row);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold the input until every transaction in flight has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_edits.size() != 0 || offered_rows.size() != 0);
    @(posedge clk);
  endtask

  task automatic run_random(int n);
    int          counted;
    int          incr_left;
    int          r;
    bit          paused;
    bit          legal;
    button_row_t row;
    counted   = 0;
    incr_left = 0;
    paused    = 1'b0;
    while (counted < n) begin
      if (!paused && counted >= n / 2) begin
        drain();
        paused = 1'b1;
      end
      legal = ($urandom_range(4) != 0);
      if (legal) begin
        row.year   = packed_bcd($urandom_range(99));
        row.month  = 5'(packed_bcd($urandom_range(12, 1)));
        row.day    = 6'(packed_bcd($urandom_range(31, 1)));
        row.wday   = 3'($urandom_range(6));
        row.hour   = 6'(packed_bcd($urandom_range(23)));
        row.minute = 7'(packed_bcd($urandom_range(59)));
      end else begin
        row.year   = 8'($urandom);
        row.month  = 5'($urandom);
        row.day    = 6'($urandom);
        row.wday   = 3'($urandom);
        row.hour   = 6'($urandom);
        row.minute = 7'($urandom);
      end
      row.typed = 1'b0;
      row.want  = NO_CHECK;
      if ($urandom_range(9) == 0) begin
        row.op = 1'($urandom);
      end else if (incr_left > 0) begin
        row.op = bcdce_pkg::OP_INCR;
        incr_left--;
      end else begin
        row.op = bcdce_pkg::OP_ADVANCE;
      end
      counted++;
      if (row.op == bcdce_pkg::OP_ADVANCE) begin
        if (ui_sel == bcdce_pkg::SEL_IDLE) begin
          ui_sel = date_en ? bcdce_pkg::SEL_YEAR : bcdce_pkg::SEL_HOUR;
        end else if (ui_sel == bcdce_pkg::SEL_MINUTE) begin
          ui_sel = bcdce_pkg::SEL_IDLE;
        end else begin
          ui_sel = bcdce_pkg::field_sel_t'(ui_sel + 3'd1);
        end
        r = $urandom_range(99);
        if (ui_sel == bcdce_pkg::SEL_IDLE || r < 20) begin
          incr_left = 0;
        end else if (r < 85) begin
          incr_left = $urandom_range(4, 1);
        end else begin
          incr_left = $urandom_range(110, 5);
        end
      end
      offer(row);
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.op          <= bcdce_pkg::OP_ADVANCE;
    in_ch.now_year    <= '0;
    in_ch.now_month   <= '0;
    in_ch.now_day     <= '0;
    in_ch.now_weekday <= '0;
    in_ch.now_hour    <= '0;
    in_ch.now_minute  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      offer(dir_rows[i]);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      cfg_we    <= 1'b1;
      cfg_wdata <= phase_date[p];
      @(posedge clk);
      cfg_we     <= 1'b0;
      date_en    = phase_date[p];
      tx_gap_pct = phase_tx[p];
      rx_gap_pct = phase_rx[p];
      run_random(phase_items[p]);
    end
    drain();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold so the block backs up.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rx_held && rx_count >= RX_HOLD_AFTER) begin
        rx_held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (RX_LONG_HOLD) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_gap_pct);
      end
    end
  end

  always @(posedge clk) begin
    button_row_t row;
    edit_rec_t   want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (offered_rows.size() == 0) begin
          report_mismatch("input transaction taken that was never offered");
        end else begin
          row  = offered_rows.pop_front();
          want = apply_button(in_ch.op, in_ch.now_year, in_ch.now_month, in_ch.now_day,
                              in_ch.now_weekday, in_ch.now_hour, in_ch.now_minute);
          if (row.typed) begin
            want = row.want;
          end
          pending_edits.push_back(want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        rx_count++;
        if (pending_edits.size() == 0) begin
          report_mismatch("result transaction with no button event pending");
        end else begin
          want = pending_edits.pop_front();
          check_field("field_sel", 8'(out_ch.field_sel), 8'(want.sel));
          check_field("edit_year", out_ch.edit_year, want.year);
          check_field("edit_month", 8'(out_ch.edit_month), 8'(want.month));
          check_field("edit_day", 8'(out_ch.edit_day), 8'(want.day));
          check_field("edit_weekday", 8'(out_ch.edit_weekday), 8'(want.wday));
          check_field("edit_hour", 8'(out_ch.edit_hour), 8'(want.hour));
          check_field("edit_minute", 8'(out_ch.edit_minute), 8'(want.minute));
          check_field("commit", 8'(out_ch.commit), 8'(want.commit));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
